>>> hdl/dcbp_pkg.sv
`default_nettype none
package dcbp_pkg;

	// Decoded operation codes
	typedef enum logic [4:0] {
		OP_CHAR    = 5'd0,
		OP_BLANK   = 5'd1,
		OP_CUSTOM  = 5'd2,
		OP_DIM     = 5'd3,
		OP_FLIP    = 5'd4,
		OP_INVERT  = 5'd5,
		OP_PALETTE = 5'd6,
		OP_MIRROR  = 5'd7,
		OP_COPY    = 5'd8,
		OP_ROLL    = 5'd9,
		OP_SHIFT   = 5'd10,
		OP_PIXEL   = 5'd11,
		OP_SENSE   = 5'd12,
		OP_RESET   = 5'd13,
		OP_COLUMN  = 5'd14,
		OP_WDT     = 5'd15,
		OP_TICK    = 5'd16,
		OP_LOOP    = 5'd17
	} op_t;

	// One decoded command
	typedef struct packed {
		op_t        op;
		logic       display;
		logic       on;
		logic [7:0] arg_a;
		logic [7:0] arg_b;
	} result_t;

	localparam logic [7:0] CASE_FOLD = 8'hdf;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_FOUR   = 8'h34;
	localparam logic [7:0] CH_FIVE   = 8'h35;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_Z  = 8'h7a;

	// Lowercase hex digit to nibble; anything else reads as zero
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'h00;
			if (c inside {[CH_ZERO:CH_NINE]}) begin
				t = c - CH_ZERO;
			end else if (c inside {[CH_LOW_A:CH_LOW_F]}) begin
				t = c - CH_LOW_A + 8'd10;
			end
			return t[3:0];
		end
	endfunction

	function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
		return {nibble_of(hi), nibble_of(lo)};
	endfunction

	// Parameter bytes a command needs; zero when the byte is no command
	function automatic logic [1:0] param_count(input logic [7:0] b);
		logic [1:0] n;
		begin
			case (b)
				"a", "A", "b", "B", "c", "C", "d", "D", "f", "F",
				"i", "I", "m", "M", "!": n = 2'd1;
				"p", "P", "l", "L": n = 2'd2;
				"r", "R", "s", "t", "T", "z", "Z": n = 2'd3;
				default: begin
					n = (b inside {[CH_ZERO:CH_NINE]}) ? 2'd2 : 2'd0;
				end
			endcase
			return n;
		end
	endfunction

	// Decode a completed command from its letter and parameter bytes
	function automatic result_t decode(input logic [7:0] cmd, input logic [7:0] p0,
			input logic [7:0] p1, input logic [7:0] p2);
		result_t    r;
		logic       which;
		logic       lower;
		logic [7:0] d1;
		logic [7:0] d2;
		begin
			r     = '0;
			which = (p0 != CH_ZERO);
			lower = (cmd inside {[CH_LOW_A:CH_LOW_Z]});
			d1    = p1 - CH_ZERO;
			d2    = p2 - CH_ZERO;
			if (cmd == CH_BANG) begin
				r.op      = OP_RESET;
				r.display = which;
			end else if (cmd inside {[CH_ZERO:CH_NINE]}) begin
				r.op      = OP_COLUMN;
				r.display = (cmd > CH_FOUR);
				r.arg_a   = (cmd > CH_FOUR) ? (cmd - CH_FIVE) : (cmd - CH_ZERO);
				r.arg_b   = hex_pair(p0, p1);
			end else begin
				case (cmd & CASE_FOLD)
					"A": begin
						r.op = OP_CHAR; r.display = !lower; r.arg_a = p0;
					end
					"B": begin
						r.op = OP_BLANK; r.display = which; r.on = lower;
					end
					"C": begin
						r.op = OP_CUSTOM; r.display = which; r.on = lower;
					end
					"D": begin
						r.op = OP_DIM; r.display = which; r.on = lower;
					end
					"F": begin
						r.op = OP_FLIP; r.display = which; r.on = !lower;
					end
					"I": begin
						r.op = OP_INVERT; r.display = which; r.on = lower;
					end
					"L": begin
						r.op = OP_PALETTE; r.display = !lower; r.arg_a = hex_pair(p0, p1);
					end
					"M": begin
						r.op = OP_MIRROR; r.display = which; r.on = lower;
					end
					"P": begin
						r.op = OP_COPY; r.display = !lower; r.arg_a = hex_pair(p0, p1);
					end
					"R": begin
						r.op = OP_ROLL; r.display = which; r.arg_a = p1; r.arg_b = d2;
					end
					"S": begin
						r.op = OP_SHIFT; r.display = which; r.arg_a = p1; r.arg_b = d2;
					end
					"T": begin
						r.op = OP_PIXEL; r.display = which; r.on = lower;
						r.arg_a = d1; r.arg_b = d2;
					end
					default: begin
						r.op = OP_SENSE; r.on = lower; r.arg_a = d1; r.arg_b = d2;
					end
				endcase
			end
			return r;
		end
	endfunction

endpackage
`default_nettype wire

>>> hdl/dcbp_in_reg.sv
`default_nettype none
module dcbp_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       take,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// Stage is free when empty or being consumed this cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule
`default_nettype wire

>>> hdl/dcbp_core.sv
`default_nettype none
module dcbp_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] byte_s1,
	output logic            emit,
	output dcbp_pkg::result_t res
);

	logic [7:0] pend_q, pend_n;
	logic [1:0] left_q, left_n;
	logic [1:0] slot_q, slot_n;
	logic       loop_q, loop_n;
	logic [7:0] store_q [3];
	logic [7:0] p_n [3];
	logic [1:0] cnt;

	// Store contents as seen by decode, including the current byte
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_n[i] = (pend_q != 8'h00 && slot_q == 2'(i)) ? byte_s1 : store_q[i];
		end
	end

	assign cnt = dcbp_pkg::param_count(byte_s1);

	// Next state and result for one byte
	always_comb begin
		pend_n = pend_q;
		left_n = left_q;
		slot_n = slot_q;
		loop_n = loop_q;
		emit   = 1'b0;
		res    = '0;
		if (pend_q != 8'h00) begin
			slot_n = slot_q + 2'd1;
			if (left_q <= 2'd1) begin
				emit   = 1'b1;
				res    = dcbp_pkg::decode(pend_q, p_n[0], p_n[1], p_n[2]);
				pend_n = 8'h00;
				left_n = 2'd0;
				slot_n = 2'd0;
			end else begin
				left_n = left_q - 2'd1;
			end
		end else begin
			left_n = 2'd0;
			slot_n = 2'd0;
			if (byte_s1 == dcbp_pkg::CH_STAR) begin
				emit   = 1'b1;
				res.op = dcbp_pkg::OP_WDT;
			end else if (byte_s1 == dcbp_pkg::CH_SLASH) begin
				emit   = 1'b1;
				res.op = dcbp_pkg::OP_TICK;
			end else if (byte_s1 == dcbp_pkg::CH_PLUS) begin
				emit   = 1'b1;
				loop_n = !loop_q;
				res.op = dcbp_pkg::OP_LOOP;
				res.on = !loop_q;
			end else if (cnt != 2'd0) begin
				pend_n = byte_s1;
				left_n = cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 8'h00;
			left_q <= 2'd0;
			slot_q <= 2'd0;
			loop_q <= 1'b0;
		end else if (take) begin
			pend_q <= pend_n;
			left_q <= left_n;
			slot_q <= slot_n;
			loop_q <= loop_n;
		end
	end

	// Parameter store, written only while a command is pending
	always_ff @(posedge clk) begin
		if (take && pend_q != 8'h00) begin
			for (int i = 0; i < 3; i++) begin
				if (slot_q == 2'(i)) begin
					store_q[i] <= byte_s1;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/dcbp_out_reg.sv
`default_nettype none
module dcbp_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire logic              emit,
	input  wire dcbp_pkg::result_t res,
	output logic                   take,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output dcbp_pkg::result_t      res_q
);

	// Stage 1 moves on when the result slot is empty or draining
	assign take = valid_s1 && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= emit;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

>>> hdl/display_command_byte_parser.sv
// Display command byte parser.
// Input channel: in_valid/in_ready with one ASCII byte (in_byte) per beat.
// Output channel: out_valid/out_ready with one decoded command per beat
// (op, display, on, arg_a, arg_b). Command letters open a pending command
// that collects one to three parameter bytes; the last one yields a beat.
// '*', '/' and '+' yield watchdog, tick and loop-toggle beats at once when
// no command is pending. Other bytes yield no beat.
// A byte lands in the input register when it is accepted, and the core
// decodes it into the result register when stage 1 moves on (take).
// Throughput: one byte per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the
// input register takes one more byte only if empty; then in_ready drops.
// Reset (arst_n low) clears the pending command, the counters, the loop
// flag and both valid flags; the parameter bytes are not cleared.
`default_nettype none
module display_command_byte_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [4:0]      op,
	output logic            display,
	output logic            on,
	output logic [7:0]      arg_a,
	output logic [7:0]      arg_b
);

	logic              take;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              emit;
	dcbp_pkg::result_t res;
	dcbp_pkg::result_t res_q;

	dcbp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	dcbp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.byte_s1 (byte_s1),
		.emit    (emit),
		.res     (res)
	);

	dcbp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.emit      (emit),
		.res       (res),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign op      = res_q.op;
	assign display = res_q.display;
	assign on      = res_q.on;
	assign arg_a   = res_q.arg_a;
	assign arg_b   = res_q.arg_b;

endmodule
`default_nettype wire

>>> tb/tb_display_command_byte_parser.sv
`default_nettype none
module tb_display_command_byte_parser;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_BYTES   = 1250;
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	// Receiver stall styles
	typedef enum logic [1:0] {
		RDY_FREE,
		RDY_COIN,
		RDY_SPARSE,
		RDY_COMB
	} rdy_mode_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte   = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [4:0] op;
	logic       display;
	logic       on;
	logic [7:0] arg_a;
	logic [7:0] arg_b;

	display_command_byte_parser DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.op        (op),
		.display   (display),
		.on        (on),
		.arg_a     (arg_a),
		.arg_b     (arg_b)
	);

	always #2 clk = ~clk;

	// Bytes waiting to be sent, commands waiting to come out
	logic [7:0]        tx_bytes[$];
	dcbp_pkg::result_t expected_cmds[$];
	int                total_bytes = 0;
	int                sent_cnt    = 0;
	int                fail_cnt    = 0;

	// Parser state as the block should hold it
	logic [7:0] pend_cmd   = 8'h00;
	int         left_cnt   = 0;
	int         slot       = 0;
	logic [7:0] store[3]   = '{8'h00, 8'h00, 8'h00};
	logic       loop_flag  = 1'b0;

	function automatic logic in_set(input string s, input logic [7:0] c);
		in_set = 1'b0;
		for (int i = 0; i < s.len(); i++)
			if (s[i] == c)
				in_set = 1'b1;
	endfunction

	function automatic int params_needed(input logic [7:0] c);
		if (in_set("aAbBcCdDfFiImM!", c))
			params_needed = 1;
		else if (in_set("pPlL0123456789", c))
			params_needed = 2;
		else if (in_set("rRstTzZ", c))
			params_needed = 3;
		else
			params_needed = 0;
	endfunction

	// Lowercase hex only; anything else counts as zero
	function automatic logic [3:0] nib(input logic [7:0] c);
		string digits = "0123456789abcdef";
		nib = 4'h0;
		for (int i = 0; i < 16; i++)
			if (digits[i] == c)
				nib = i[3:0];
	endfunction

	function automatic dcbp_pkg::result_t decode_cmd(input logic [7:0] cmd,
			input logic [7:0] a0, input logic [7:0] a1, input logic [7:0] a2);
		dcbp_pkg::result_t r;
		logic              which;
		logic              lower;
		logic [7:0]        d1;
		logic [7:0]        d2;
		r     = '0;
		which = (a0 != "0");
		lower = (cmd >= "a" && cmd <= "z");
		d1    = a1 - "0";
		d2    = a2 - "0";
		if (cmd == "!") begin
			r.op      = dcbp_pkg::OP_RESET;
			r.display = which;
		end else if (cmd >= "0" && cmd <= "9") begin
			r.op      = dcbp_pkg::OP_COLUMN;
			r.display = (cmd >= "5");
			r.arg_a   = (cmd >= "5") ? cmd - "5" : cmd - "0";
			r.arg_b   = {nib(a0), nib(a1)};
		end else begin
			case (cmd & dcbp_pkg::CASE_FOLD)
				"A": begin
					r.op = dcbp_pkg::OP_CHAR; r.display = !lower; r.arg_a = a0;
				end
				"B": begin
					r.op = dcbp_pkg::OP_BLANK; r.display = which; r.on = lower;
				end
				"C": begin
					r.op = dcbp_pkg::OP_CUSTOM; r.display = which; r.on = lower;
				end
				"D": begin
					r.op = dcbp_pkg::OP_DIM; r.display = which; r.on = lower;
				end
				"F": begin
					r.op = dcbp_pkg::OP_FLIP; r.display = which; r.on = !lower;
				end
				"I": begin
					r.op = dcbp_pkg::OP_INVERT; r.display = which; r.on = lower;
				end
				"L": begin
					r.op = dcbp_pkg::OP_PALETTE; r.display = !lower;
					r.arg_a = {nib(a0), nib(a1)};
				end
				"M": begin
					r.op = dcbp_pkg::OP_MIRROR; r.display = which; r.on = lower;
				end
				"P": begin
					r.op = dcbp_pkg::OP_COPY; r.display = !lower;
					r.arg_a = {nib(a0), nib(a1)};
				end
				"R": begin
					r.op = dcbp_pkg::OP_ROLL; r.display = which;
					r.arg_a = a1; r.arg_b = d2;
				end
				"S": begin
					r.op = dcbp_pkg::OP_SHIFT; r.display = which;
					r.arg_a = a1; r.arg_b = d2;
				end
				"T": begin
					r.op = dcbp_pkg::OP_PIXEL; r.display = which; r.on = lower;
					r.arg_a = d1; r.arg_b = d2;
				end
				default: begin
					r.op = dcbp_pkg::OP_SENSE; r.on = lower;
					r.arg_a = d1; r.arg_b = d2;
				end
			endcase
		end
		return r;
	endfunction

	function automatic dcbp_pkg::result_t event_beat(input dcbp_pkg::op_t o,
			input logic flag);
		dcbp_pkg::result_t r;
		r    = '0;
		r.op = o;
		r.on = flag;
		return r;
	endfunction

	// Advance the parser by one accepted byte, queue any command it completes
	task automatic parse_byte(input logic [7:0] b);
		int n;
		if (pend_cmd != 8'h00) begin
			if (slot < 3)
				store[slot] = b;
			slot++;
			if (left_cnt <= 1) begin
				expected_cmds.push_back(decode_cmd(pend_cmd, store[0], store[1], store[2]));
				pend_cmd = 8'h00;
				left_cnt = 0;
				slot     = 0;
			end else begin
				left_cnt--;
			end
		end else begin
			left_cnt = 0;
			slot     = 0;
			if (b == "*") begin
				expected_cmds.push_back(event_beat(dcbp_pkg::OP_WDT, 1'b0));
			end else if (b == "/") begin
				expected_cmds.push_back(event_beat(dcbp_pkg::OP_TICK, 1'b0));
			end else if (b == "+") begin
				loop_flag = !loop_flag;
				expected_cmds.push_back(event_beat(dcbp_pkg::OP_LOOP, loop_flag));
			end else begin
				n = params_needed(b);
				if (n != 0) begin
					pend_cmd = b;
					left_cnt = n;
				end
			end
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		tx_bytes.push_back(b);
		total_bytes++;
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// Parameter byte: mostly digits and hex, sometimes '0', sometimes anything
	function automatic logic [7:0] rand_param();
		string hexd = "0123456789abcdef";
		case ($urandom_range(0, 3))
			0: rand_param = 8'("0" + $urandom_range(0, 9));
			1: rand_param = hexd[$urandom_range(0, 15)];
			2: rand_param = "0";
			default: rand_param = 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Sender: bursts of beats with random gaps
	int gap_left   = 0;
	int burst_left = 0;

	always @(posedge clk or negedge arst_n) begin : drive
		logic       nv;
		logic [7:0] nb;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_byte    <= 8'h00;
			gap_left   = 0;
			burst_left = 0;
		end else begin
			nv = in_valid;
			nb = in_byte;
			if (in_valid && in_ready) begin
				parse_byte(in_byte);
				sent_cnt <= sent_cnt + 1;
				nv = 1'b0;
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (tx_bytes.size() != 0) begin
					nv = 1'b1;
					nb = tx_bytes.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 7) == 0) ?
							$urandom_range(60, 150) : $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			in_valid <= nv;
			in_byte  <= nb;
		end
	end

	// One long receiver hold-off once traffic is well under way
	logic hold_on   = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_on   <= 1'b0;
			hold_done <= 1'b0;
			hold_left <= 0;
		end else if (!hold_done && sent_cnt >= HOLD_AFTER) begin
			hold_on   <= 1'b1;
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_on) begin
			if (hold_left == 0)
				hold_on <= 1'b0;
			else
				hold_left <= hold_left - 1;
		end
	end

	// Receiver: each stall style is held for a random span, then picked anew
	rdy_mode_t rdy_mode  = RDY_FREE;
	int        mode_left = 0;

	always @(posedge clk or negedge arst_n) begin : recv
		logic r;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rdy_mode  = RDY_FREE;
			mode_left = 0;
		end else begin
			if (mode_left == 0) begin
				rdy_mode  = rdy_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end
			case (rdy_mode)
				RDY_FREE:   r = 1'b1;
				RDY_COIN:   r = 1'($urandom_range(0, 1));
				RDY_SPARSE: r = ($urandom_range(0, 3) == 0);
				default:    r = (mode_left % 5 != 0);
			endcase
			out_ready <= r && !hold_on;
		end
	end

	// Check each output beat against the oldest predicted command
	always @(posedge clk) begin : check
		dcbp_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_cmds.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("unexpected beat: op=%0d display=%0b on=%0b a=%02h b=%02h",
						op, display, on, arg_a, arg_b);
			end else begin
				want = expected_cmds.pop_front();
				if (op != want.op || display != want.display || on != want.on ||
						arg_a != want.arg_a || arg_b != want.arg_b) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("mismatch: exp op=%0d d=%0b on=%0b a=%02h b=%02h got op=%0d d=%0b on=%0b a=%02h b=%02h",
							want.op, want.display, want.on, want.arg_a, want.arg_b,
							op, display, on, arg_a, arg_b);
				end
			end
		end
	end

	initial begin : stimulus
		string cmd_set;
		string evt_set;
		logic [7:0] c;
		cmd_set = "aAbBcCdDfFiImM!pPlLrRstTzZ0123456789";
		evt_set = "*/+S";

		// Ignored bytes, then the events
		push_byte(8'h00);
		push_byte(8'hff);
		push_str("S*/++");
		// A command of every kind, with extreme and odd parameters
		push_str("aZ");
		push_str("A");
		push_byte(8'hff);
		push_str("B0c1D0fxF0I0m*Mq");
		push_str("lffP0FL9a");
		push_str("r0x9R1");
		push_byte(8'h00);
		push_byte(8'hff);
		push_str("s0Z0T0z0t190z");
		push_byte(8'hff);
		push_str("00Z000!0!1");
		push_str("0ab49f5f09ff");

		// Mostly well-formed commands with random parameters, some noise
		while (total_bytes < RAND_BYTES) begin
			case ($urandom_range(0, 9))
				8: push_byte(evt_set[$urandom_range(0, 3)]);
				9: push_byte(8'($urandom_range(0, 255)));
				default: begin
					c = cmd_set[$urandom_range(0, cmd_set.len() - 1)];
					push_byte(c);
					repeat (params_needed(c))
						push_byte(rand_param());
				end
			endcase
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_cnt != total_bytes)
			@(posedge clk);
		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_cmds.size() != 0)
			fail_cnt++;
		if (fail_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Hard stop if the block hangs
	initial begin
		#1ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
hdl/dcbp_pkg.sv
hdl/dcbp_in_reg.sv
hdl/dcbp_core.sv
hdl/dcbp_out_reg.sv
hdl/display_command_byte_parser.sv
tb/tb_display_command_byte_parser.sv
